### rtl/prr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the Newton root refine unit.
// No dependencies.
package prr_pkg;

  localparam int DataW     = 32;
  localparam int FracW     = 16;
  localparam int NumW      = DataW + FracW;
  localparam int DivBits   = 2;
  localparam int DivStages = NumW / DivBits;
  localparam int CoefN     = 7;
  localparam int SlotW     = DataW + 1;

  localparam logic signed [63:0] SatMax = 64'sd2147483647;
  localparam logic signed [63:0] SatMin = -64'sd2147483648;

  typedef logic signed [DataW-1:0] q_t;

  typedef enum logic [2:0] {
    REG_DEGREE,
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4,
    REG_COEF_5,
    REG_COEF_6
  } reg_idx_t;

  // Horner accumulators for f and f'
  typedef struct packed {
    q_t x;
    q_t f;
    q_t df;
  } hrn_t;

  // Restoring divider state; den, rem, num and quot are magnitudes
  typedef struct packed {
    q_t               x;
    logic             zero;
    logic             neg;
    logic [DataW-1:0] den;
    logic [DataW-1:0] rem;
    logic [NumW-1:0]  num;
    logic [NumW-1:0]  quot;
  } div_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    q_t r;
    if (v > SatMax) r = 32'sh7FFF_FFFF;
    else if (v < SatMin) r = 32'sh8000_0000;
    else r = v[DataW-1:0];
    return r;
  endfunction

  // sat(round(a*b) + c), round = floor((p + 2^15) / 2^16)
  function automatic q_t qmul_add(input q_t a, input q_t b, input q_t c);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b);
    r = (p + 64'sd32768) >>> FracW;
    return sat32(r + 64'(c));
  endfunction

  function automatic q_t dcoef(input logic [2:0] k, input q_t c);
    logic signed [63:0] p;
    p = 64'(c) * $signed({61'd0, k});
    return sat32(p);
  endfunction

endpackage

### rtl/prr_hrn_stage.sv
`timescale 1ns / 1ps
// One Horner stage: folds coefficient K-1 into f and K*coef_K into f'.
// Depends on prr_pkg.
module prr_hrn_stage #(
  parameter int K      = 1,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  prr_pkg::hrn_t       in_d,
  input  logic [SIDE_W-1:0]   in_side,
  input  logic [2:0]          deg,
  input  prr_pkg::q_t         coef,
  input  prr_pkg::q_t         dcoef,
  output logic                out_valid,
  output prr_pkg::hrn_t       out_d,
  output logic [SIDE_W-1:0]   out_side
);

  localparam logic [3:0] KVal = 4'(K);

  logic          f_on;
  logic          df_on;
  prr_pkg::hrn_t d_next;

  assign f_on  = KVal <= {1'b0, deg};
  assign df_on = KVal < {1'b0, deg};

  always_comb begin
    d_next = in_d;
    if (f_on) d_next.f = prr_pkg::qmul_add(in_d.f, in_d.x, coef);
    if (df_on) d_next.df = prr_pkg::qmul_add(in_d.df, in_d.x, dcoef);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_d    <= d_next;
      out_side <= in_side;
    end
  end

endmodule

### rtl/prr_div_stage.sv
`timescale 1ns / 1ps
// One stage of the restoring divider, DivBits quotient bits per stage.
// Depends on prr_pkg.
module prr_div_stage #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  prr_pkg::div_t     in_d,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output prr_pkg::div_t     out_d,
  output logic [SIDE_W-1:0] out_side
);

  localparam int DW = prr_pkg::DataW;
  localparam int NW = prr_pkg::NumW;

  prr_pkg::div_t d_next;
  logic [DW:0]   r;
  logic          ge;

  always_comb begin
    d_next = in_d;
    r      = '0;
    ge     = 1'b0;
    for (int j = 0; j < prr_pkg::DivBits; j++) begin
      r           = {d_next.rem, d_next.num[NW-1]};
      d_next.num  = {d_next.num[NW-2:0], 1'b0};
      ge          = r >= {1'b0, d_next.den};
      d_next.rem  = ge ? DW'(r - {1'b0, d_next.den}) : r[DW-1:0];
      d_next.quot = {d_next.quot[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_d    <= d_next;
      out_side <= in_side;
    end
  end

endmodule

### rtl/prr_step.sv
`timescale 1ns / 1ps
// One Newton step: Horner stages for f and f', divider prep, divider, update.
// Depends on prr_pkg, prr_hrn_stage, prr_div_stage.
module prr_step #(
  parameter int MAX_DEGREE = 6,
  parameter int SIDE_W     = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  prr_pkg::q_t       in_x,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [2:0]        deg,
  input  prr_pkg::q_t       coefs  [prr_pkg::CoefN],
  input  prr_pkg::q_t       dcoefs [prr_pkg::CoefN],
  output logic              out_valid,
  output prr_pkg::q_t       out_x,
  output logic              out_zero,
  output logic [SIDE_W-1:0] out_side
);

  localparam int DW = prr_pkg::DataW;
  localparam int NS = prr_pkg::DivStages;
  localparam int WW = prr_pkg::NumW + 2;

  logic              h_v [MAX_DEGREE+1];
  prr_pkg::hrn_t     h_d [MAX_DEGREE+1];
  logic [SIDE_W-1:0] h_s [MAX_DEGREE+1];

  logic              v_v [NS+1];
  prr_pkg::div_t     v_d [NS+1];
  logic [SIDE_W-1:0] v_s [NS+1];

  assign h_v[0] = in_valid;
  // field order x, f, df
  assign h_d[0] = {in_x, coefs[deg], dcoefs[deg]};
  assign h_s[0] = in_side;

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_hrn
    prr_hrn_stage #(.K(MAX_DEGREE - i), .SIDE_W(SIDE_W)) u_hrn (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (h_v[i]),
      .in_d     (h_d[i]),
      .in_side  (h_s[i]),
      .deg      (deg),
      .coef     (coefs[MAX_DEGREE-i-1]),
      .dcoef    (dcoefs[MAX_DEGREE-i]),
      .out_valid(h_v[i+1]),
      .out_d    (h_d[i+1]),
      .out_side (h_s[i+1])
    );
  end

  // divider prep: magnitudes and quotient sign
  prr_pkg::hrn_t hd;
  prr_pkg::div_t p_next;
  logic [DW-1:0] absf;
  logic [DW-1:0] absdf;

  assign hd = h_d[MAX_DEGREE];

  always_comb begin
    absf        = hd.f[DW-1] ? -hd.f : hd.f;
    absdf       = hd.df[DW-1] ? -hd.df : hd.df;
    p_next.x    = hd.x;
    p_next.zero = hd.df == '0;
    p_next.neg  = hd.f[DW-1] ^ hd.df[DW-1];
    p_next.den  = absdf;
    p_next.rem  = '0;
    p_next.num  = {absf, {prr_pkg::FracW{1'b0}}};
    p_next.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_v[0] <= 1'b0;
    end else if (en) begin
      v_v[0] <= h_v[MAX_DEGREE];
    end
    if (en) begin
      v_d[0] <= p_next;
      v_s[0] <= h_s[MAX_DEGREE];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_div
    prr_div_stage #(.SIDE_W(SIDE_W)) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v_v[j]),
      .in_d     (v_d[j]),
      .in_side  (v_s[j]),
      .out_valid(v_v[j+1]),
      .out_d    (v_d[j+1]),
      .out_side (v_s[j+1])
    );
  end

  // update: x - q, saturated; zero slope holds x
  prr_pkg::div_t    vd;
  logic signed [WW-1:0] q;
  logic signed [WW-1:0] diff;
  prr_pkg::q_t      x_next;

  assign vd = v_d[NS];

  always_comb begin
    q      = vd.neg ? -$signed({2'b00, vd.quot}) : $signed({2'b00, vd.quot});
    diff   = WW'(vd.x) - q;
    x_next = vd.zero ? vd.x : prr_pkg::sat32(64'(diff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_v[NS];
    end
    if (en) begin
      out_x    <= x_next;
      out_zero <= vd.zero;
      out_side <= v_s[NS];
    end
  end

endmodule

### rtl/prr_ser.sv
`timescale 1ns / 1ps
// Output register: holds all iterates of one guess and sends them one per transfer.
// Depends on prr_pkg.
module prr_ser #(
  parameter int STEP_COUNT = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load_valid,
  input  logic [STEP_COUNT*prr_pkg::SlotW-1:0] load_side,
  input  logic                                out_stall,
  output logic                                free,
  output logic                                out_valid,
  output prr_pkg::q_t                         estimate,
  output logic [2:0]                          step_index,
  output logic                                last_step,
  output logic                                zero_slope
);

  localparam int IW = STEP_COUNT > 1 ? $clog2(STEP_COUNT) : 1;
  localparam int SW = prr_pkg::SlotW;

  logic                       busy;
  logic [IW-1:0]              idx;
  logic [STEP_COUNT*SW-1:0]   side;
  logic                       last_idx;
  logic [SW-1:0]              slot;

  assign last_idx = idx == IW'(STEP_COUNT - 1);
  assign free     = !busy || (last_idx && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (free && load_valid) begin
      busy <= 1'b1;
    end else if (busy && !out_stall && last_idx) begin
      busy <= 1'b0;
    end
    if (free && load_valid) begin
      idx  <= '0;
      side <= load_side;
    end else if (busy && !out_stall && !last_idx) begin
      idx <= idx + 1'b1;
    end
  end

  assign slot       = side[idx*SW +: SW];
  assign out_valid  = busy;
  assign estimate   = slot[prr_pkg::DataW-1:0];
  assign zero_slope = slot[SW-1];
  assign step_index = 3'({1'b0, idx} + 1'b1);
  assign last_step  = last_idx;

endmodule

### rtl/polynomial_newton_root_refine_unit.sv
`timescale 1ns / 1ps
// Top level of the Newton root refine unit: config registers, step chain, output register.
// Depends on prr_pkg, prr_step, prr_ser.
//
//   channel | dir | handshake            | payload
//   cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in  | in_valid/in_stall    | start_guess
//   out     | out | out_valid/out_stall  | estimate, step_index, last_step, zero_slope
//
// A guess can enter every cycle while in_stall is low; the output port sends one iterate
// per cycle while out_stall is low, so the single output port sets the sustained guess rate.
// Reset: synchronous; degree returns to 1, coefficients to 0, pipeline emptied.
// out_stall freezes the whole pipeline only once its last stage holds an untaken item.
module polynomial_newton_root_refine_unit #(
  parameter int STEP_COUNT = 5,
  parameter int MAX_DEGREE = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] start_guess,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] estimate,
  output logic [2:0]         step_index,
  output logic               last_step,
  output logic               zero_slope
);

  localparam int SW     = prr_pkg::SlotW;
  localparam int SIDE_W = STEP_COUNT * SW;

  logic [2:0]  degree;
  prr_pkg::q_t coefs  [prr_pkg::CoefN];
  prr_pkg::q_t dcoefs [prr_pkg::CoefN];
  logic [2:0]  eff_deg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= 3'd1;
      for (int k = 0; k < prr_pkg::CoefN; k++) coefs[k] <= '0;
    end else if (cfg_valid) begin
      unique case (prr_pkg::reg_idx_t'(cfg_index))
        prr_pkg::REG_DEGREE: degree   <= cfg_data[2:0];
        prr_pkg::REG_COEF_0: coefs[0] <= cfg_data;
        prr_pkg::REG_COEF_1: coefs[1] <= cfg_data;
        prr_pkg::REG_COEF_2: coefs[2] <= cfg_data;
        prr_pkg::REG_COEF_3: coefs[3] <= cfg_data;
        prr_pkg::REG_COEF_4: coefs[4] <= cfg_data;
        prr_pkg::REG_COEF_5: coefs[5] <= cfg_data;
        prr_pkg::REG_COEF_6: coefs[6] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_deg = (degree > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : degree;

  always_comb begin
    for (int k = 0; k < prr_pkg::CoefN; k++) dcoefs[k] = prr_pkg::dcoef(3'(k), coefs[k]);
  end

  logic              st_v    [STEP_COUNT];
  prr_pkg::q_t       st_x    [STEP_COUNT];
  logic              st_z    [STEP_COUNT];
  logic [SIDE_W-1:0] st_side [STEP_COUNT];
  logic [SIDE_W-1:0] merged  [STEP_COUNT];
  logic              adv;
  logic              ser_free;

  for (genvar s = 0; s < STEP_COUNT; s++) begin : g_step
    logic              iv;
    prr_pkg::q_t       ix;
    logic [SIDE_W-1:0] is;

    if (s == 0) begin : g_first
      assign iv = in_valid;
      assign ix = start_guess;
      assign is = '0;
    end else begin : g_next
      assign iv = st_v[s-1];
      assign ix = st_x[s-1];
      assign is = merged[s-1];
    end

    prr_step #(.MAX_DEGREE(MAX_DEGREE), .SIDE_W(SIDE_W)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (iv),
      .in_x     (ix),
      .in_side  (is),
      .deg      (eff_deg),
      .coefs    (coefs),
      .dcoefs   (dcoefs),
      .out_valid(st_v[s]),
      .out_x    (st_x[s]),
      .out_zero (st_z[s]),
      .out_side (st_side[s])
    );

    // slot s is still zero here, so OR drops this step's iterate into place
    assign merged[s] = st_side[s] | (SIDE_W'({st_z[s], st_x[s]}) << (s * SW));
  end

  assign adv      = !st_v[STEP_COUNT-1] || ser_free;
  assign in_stall = !adv;

  prr_ser #(.STEP_COUNT(STEP_COUNT)) u_ser (
    .clk       (clk),
    .rst       (rst),
    .load_valid(st_v[STEP_COUNT-1]),
    .load_side (merged[STEP_COUNT-1]),
    .out_stall (out_stall),
    .free      (ser_free),
    .out_valid (out_valid),
    .estimate  (estimate),
    .step_index(step_index),
    .last_step (last_step),
    .zero_slope(zero_slope)
  );

endmodule

### rtl/prr_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the Newton root refine unit.
// Depends on polynomial_newton_root_refine_unit (bound to it below).
module prr_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] estimate,
  input logic [2:0]         step_index,
  input logic               last_step
);

  a_out_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(step_index))
    else $error("stalled result changed");

  a_run_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_step |=> out_valid)
    else $error("gap inside one guess's run of iterates");

  a_step_incr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_step |=> step_index == $past(step_index) + 3'd1)
    else $error("step index did not advance by one");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> step_index != 3'd0)
    else $error("step index zero");

endmodule

bind polynomial_newton_root_refine_unit prr_checker u_prr_checker (.*);
